### sv/bqdo_pkg.sv
`timescale 1ns / 1ps
package bqdo_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int LIMIT_W   = 5;
  localparam int COUNT_W   = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_TAKE_OLD = 2'd1,
    OP_TAKE_KEY = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DROP      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   out_key;
    logic [PAY_W-1:0]   out_payload;
    logic [COUNT_W-1:0] count;
    logic               full_res;
  } res_t;

  // per-cell update control
  typedef struct packed {
    logic shift;  // take the entry of the next cell
    logic load;   // take the new entry
  } cell_ctl_t;

endpackage

### sv/bqdo_cell.sv
`timescale 1ns / 1ps
module bqdo_cell
  import bqdo_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic             valid_i,
  input  logic             hit_i,
  input  logic [KEY_W-1:0] srch_key,
  input  logic [KEY_W-1:0] nbr_key,
  input  logic [PAY_W-1:0] nbr_pay,
  input  logic [KEY_W-1:0] new_key,
  input  logic [PAY_W-1:0] new_pay,
  output logic [KEY_W-1:0] key_o,
  output logic [PAY_W-1:0] pay_o,
  output logic             hit_o,
  output logic             first_o
);

  logic [KEY_W-1:0] key_r;
  logic [PAY_W-1:0] pay_r;
  logic             match;

  assign match   = valid_i && (key_r == srch_key);
  assign hit_o   = hit_i | match;
  assign first_o = match & ~hit_i;
  assign key_o   = key_r;
  assign pay_o   = pay_r;

  // load wins over shift
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= new_key;
      pay_r <= new_pay;
    end else if (ctl.shift) begin
      key_r <= nbr_key;
      pay_r <= nbr_pay;
    end
  end

endmodule

### sv/bounded_queue_drop_oldest_keyed_take.sv
`timescale 1ns / 1ps
// one request per clock, its result strobes on out_strobe in the cycle after start
// throughput: one request every cycle, busy never rises; the key compare rippling
//   through the row of cells (first match wins) sets the critical path
// reset (rst_n low, synchronous): queue empty, storage limit back to 16;
//   entry contents are not cleared, slots past the count are never read
// the receiver cannot stall: each result shows for exactly one cycle
module bounded_queue_drop_oldest_keyed_take
  import bqdo_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  req_t               in_req,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic               out_strobe,
  output res_t               out_res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // control state
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic               out_strobe_r;
  res_t               out_res_r, out_res_nxt;

  // row of cells
  logic [KEY_W-1:0] cell_key [DEPTH];
  logic [PAY_W-1:0] cell_pay [DEPTH];
  logic [DEPTH:0]   hit_chain;
  logic [DEPTH-1:0] first;
  logic [DEPTH-1:0] valid;
  cell_ctl_t        ctl [DEPTH];

  logic             accept;
  logic [LIM_W-1:0] eff_limit;
  logic [LIM_W-1:0] count_ext;
  logic             drop;
  logic             load_en;
  logic [CNT_W-1:0] load_idx;
  logic             shift_all;
  logic             key_take;
  logic             found;
  logic [KEY_W-1:0] sel_key;
  logic [PAY_W-1:0] sel_pay;

  // every request completes in its own cycle
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // storage limit: zero acts as one, anything above the depth as the depth
  always_comb begin
    eff_limit = LIM_W'(limit_r);
    if (limit_r == '0) begin
      eff_limit = LIM_W'(1);
    end else if (LIM_W'(limit_r) > LIM_W'(DEPTH)) begin
      eff_limit = LIM_W'(DEPTH);
    end
  end

  assign count_ext = LIM_W'(count_r);

  // an add on a full queue drops the front entry, the rest slide down one cell
  assign drop      = (count_ext >= eff_limit) && (count_r != '0);
  assign load_en   = accept && (in_req.op == OP_ADD) &&
                     (drop || (count_r < CNT_W'(DEPTH)));
  assign load_idx  = drop ? (count_r - CNT_W'(1)) : count_r;
  assign shift_all = accept && (((in_req.op == OP_ADD) && drop) ||
                     ((in_req.op == OP_TAKE_OLD) && (count_r != '0)));
  assign key_take  = accept && (in_req.op == OP_TAKE_KEY);

  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[DEPTH];

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [KEY_W-1:0] nbr_key;
      logic [PAY_W-1:0] nbr_pay;

      // the last cell pulls in nothing useful, the count hides it
      if (gi == DEPTH - 1) begin : g_tail
        assign nbr_key = '0;
        assign nbr_pay = '0;
      end else begin : g_mid
        assign nbr_key = cell_key[gi+1];
        assign nbr_pay = cell_pay[gi+1];
      end

      assign valid[gi]     = CNT_W'(gi) < count_r;
      assign ctl[gi].load  = load_en && (load_idx == CNT_W'(gi));
      // keyed take closes the gap from the first match upward
      assign ctl[gi].shift = shift_all || (key_take && hit_chain[gi+1]);

      bqdo_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[gi]),
        .valid_i  (valid[gi]),
        .hit_i    (hit_chain[gi]),
        .srch_key (in_req.key),
        .nbr_key  (nbr_key),
        .nbr_pay  (nbr_pay),
        .new_key  (in_req.key),
        .new_pay  (in_req.payload),
        .key_o    (cell_key[gi]),
        .pay_o    (cell_pay[gi]),
        .hit_o    (hit_chain[gi+1]),
        .first_o  (first[gi])
      );
    end
  endgenerate

  // pick the entry at the first match, at most one cell is flagged
  always_comb begin
    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_key = sel_key | (first[i] ? cell_key[i] : '0);
      sel_pay = sel_pay | (first[i] ? cell_pay[i] : '0);
    end
  end

  // next count and result of the request
  always_comb begin
    count_nxt   = count_r;
    out_res_nxt = '0;
    case (in_req.op)
      OP_ADD: begin
        if (drop) begin
          out_res_nxt.status = ST_DROP;
        end else if (count_r < CNT_W'(DEPTH)) begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_TAKE_OLD: begin
        if (count_r == '0) begin
          out_res_nxt.status = ST_EMPTY;
        end else begin
          out_res_nxt.out_key     = cell_key[0];
          out_res_nxt.out_payload = cell_pay[0];
          count_nxt               = count_r - CNT_W'(1);
        end
      end
      OP_TAKE_KEY: begin
        if (found) begin
          out_res_nxt.out_key     = sel_key;
          out_res_nxt.out_payload = sel_pay;
          count_nxt               = count_r - CNT_W'(1);
        end else begin
          out_res_nxt.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // unused op code leaves the queue alone
        count_nxt = count_r;
      end
    endcase
    out_res_nxt.count    = COUNT_W'(count_nxt);
    out_res_nxt.full_res = LIM_W'(count_nxt) >= eff_limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      limit_r      <= LIMIT_RST;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // result payload carries no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

  // every accepted request strobes a result in the next cycle
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe)
    else $error("accepted request without result strobe");

  // a take from a non-empty queue removes exactly one entry
  a_take_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_req.op == OP_TAKE_OLD) && (count_r != '0)
    |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("take oldest did not shrink the queue by one");

  // a drop keeps the queue at the same, non-zero fill
  a_drop_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_res.status == ST_DROP)
    |-> (count_r == $past(count_r)) && (count_r != '0))
    else $error("drop changed the fill level");

  // fill level stays within the row of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> count_r <= CNT_W'(DEPTH))
    else $error("fill level beyond depth");

endmodule
